>>> rtl/voxel_face_cull_mesher_unit_defines.svh
// ---------------------------------------------------------------------------
// voxel face cull mesher - assertion macros
// Shared property wrappers used by the port checker.
// ---------------------------------------------------------------------------
`ifndef VOXEL_FACE_CULL_MESHER_UNIT_DEFINES_SVH
`define VOXEL_FACE_CULL_MESHER_UNIT_DEFINES_SVH

// same-cycle implication, disabled during reset
`define VFCM_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define VFCM_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/vfcm_pkg.sv
// ---------------------------------------------------------------------------
// vfcm_pkg
// Types, constants and control structs shared by the voxel mesher modules.
// ---------------------------------------------------------------------------
package vfcm_pkg;

    // cube geometry
    localparam int SIDE      = 16;
    localparam int DEPTH     = SIDE * SIDE * SIDE;
    localparam int ADDR_W    = $clog2(DEPTH);
    localparam int COORD_W   = 4;
    localparam int CODE_W    = 8;
    localparam int KIND_W    = 2;
    localparam int FACE_W    = 3;
    localparam int COUNT_W   = 15;
    localparam int BASE_W    = COUNT_W + 2;
    localparam int NUM_FACES = 6;
    localparam int SCAN_W    = 3;

    // configuration registers
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_SOLID = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AIR   = 1'd1;
    localparam logic [CODE_W-1:0] SOLID_RESET = 8'd1;
    localparam logic [CODE_W-1:0] AIR_RESET   = 8'd0;

    // item kinds
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_MESH  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_START = 2'd2;

    // face numbers
    localparam logic [FACE_W-1:0] FACE_LEFT   = 3'd0;
    localparam logic [FACE_W-1:0] FACE_RIGHT  = 3'd1;
    localparam logic [FACE_W-1:0] FACE_BOTTOM = 3'd2;
    localparam logic [FACE_W-1:0] FACE_TOP    = 3'd3;
    localparam logic [FACE_W-1:0] FACE_BACK   = 3'd4;
    localparam logic [FACE_W-1:0] FACE_FRONT  = 3'd5;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [COORD_W-1:0] pos_x;
        logic [COORD_W-1:0] pos_y;
        logic [COORD_W-1:0] pos_z;
        logic [CODE_W-1:0]  block_value;
    } in_item_t;

    typedef struct packed {
        logic [COORD_W-1:0] quad_x;
        logic [COORD_W-1:0] quad_y;
        logic [COORD_W-1:0] quad_z;
        logic [FACE_W-1:0]  face;
        logic [BASE_W-1:0]  vertex_base;
        logic               last;
    } out_item_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_SCAN,
        ST_EMIT
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic              load_item;
        logic              wr_voxel;
        logic              clr_count;
        logic              clr_mask;
        logic              rd_en;
        logic              rd_nb;
        logic [FACE_W-1:0] rd_face;
        logic              eval_en;
        logic [FACE_W-1:0] eval_face;
        logic              emit;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [KIND_W-1:0] in_kind;
        logic              in_inside;
        logic              centre_solid;
        logic              mask_any;
        logic              out_free;
    } status_t;

    // true when all three coordinates lie inside the cube
    function automatic logic coord_inside(logic [COORD_W-1:0] x,
                                          logic [COORD_W-1:0] y,
                                          logic [COORD_W-1:0] z);
        localparam logic [COORD_W:0] SideC = (COORD_W + 1)'(SIDE);
        return ({1'b0, x} < SideC) && ({1'b0, y} < SideC) && ({1'b0, z} < SideC);
    endfunction

endpackage

>>> rtl/voxel_face_cull_mesher_unit.sv
// ---------------------------------------------------------------------------
// voxel_face_cull_mesher_unit
// Face-culling mesher over a 16x16x16 store of 8-bit block codes.
// ---------------------------------------------------------------------------
// Write, start and unused items, and mesh items outside the cube, are taken
// without leaving idle. A mesh item reads the centre voxel and, if it holds
// the solid code, its six neighbours one after another through the single
// port of the voxel store, then emits a quad per exposed face, waiting while
// the output side stalls. The quad register parts the two sides, so the next
// item is taken while the last quad still waits for its transfer. The store
// has no reset; the user must write voxels before meshing reads them.
// ---------------------------------------------------------------------------
module voxel_face_cull_mesher_unit
    import vfcm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_item,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CODE_W-1:0]    cfg_data
);

    cmd_t    cmd;
    status_t status;

    // sequencer
    vfcm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    // store and quad datapath
    vfcm_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_item  (out_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

>>> rtl/vfcm_ctrl.sv
// ---------------------------------------------------------------------------
// vfcm_ctrl
// Sequencer: accepts items, steps the centre and neighbour reads, then
// drains the exposed-face mask into the output register.
// ---------------------------------------------------------------------------
module vfcm_ctrl
    import vfcm_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t            state_reg, state_next;
    logic [SCAN_W-1:0] scan_reg, scan_next;
    logic              take;
    logic              mesh_go;

    localparam logic [SCAN_W-1:0] ScanLast = SCAN_W'(NUM_FACES);

    // accepted item decode
    assign take    = in_valid && (state_reg == ST_IDLE);
    assign mesh_go = take && (status.in_kind == KIND_MESH) && status.in_inside;

    // state and scan index registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            scan_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            scan_reg  <= scan_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        scan_next  = scan_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (mesh_go)
                begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK:
            begin
                state_next = ST_SCAN;
                scan_next  = '0;
            end
            ST_SCAN:
            begin
                if (scan_reg == '0 && !status.centre_solid)
                begin
                    state_next = ST_IDLE;
                end
                else if (scan_reg == ScanLast)
                begin
                    state_next = ST_EMIT;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (!status.mask_any)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready      = 1'b0;
        cmd           = '0;
        cmd.rd_face   = scan_reg;
        cmd.eval_face = scan_reg - 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready      = 1'b1;
                cmd.load_item = take;
                cmd.wr_voxel  = take && (status.in_kind == KIND_WRITE) && status.in_inside;
                cmd.clr_count = take && (status.in_kind == KIND_START);
            end
            ST_LOOK:
            begin
                cmd.rd_en    = 1'b1;
                cmd.clr_mask = 1'b1;
            end
            ST_SCAN:
            begin
                cmd.rd_en   = (scan_reg != ScanLast);
                cmd.rd_nb   = 1'b1;
                cmd.eval_en = (scan_reg != '0);
            end
            ST_EMIT:
            begin
                cmd.emit = status.mask_any && status.out_free;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/vfcm_datapath.sv
// ---------------------------------------------------------------------------
// vfcm_datapath
// Voxel store, configuration codes, exposed-face mask, quad counter and
// output register.
// ---------------------------------------------------------------------------
module vfcm_datapath
    import vfcm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  in_item_t             in_item,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CODE_W-1:0]    cfg_data,
    output out_item_t            out_item,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  cmd_t                 cmd,
    output status_t              status
);

    logic [CODE_W-1:0]    mem [DEPTH];
    logic [CODE_W-1:0]    rd_data_reg;
    in_item_t             item_reg;
    logic [CODE_W-1:0]    solid_reg;
    logic [CODE_W-1:0]    air_reg;
    logic [COUNT_W-1:0]   count_reg;
    logic [NUM_FACES-1:0] mask_reg, mask_next;
    out_item_t            out_item_reg;
    logic                 out_valid_reg;
    logic [ADDR_W-1:0]    wr_addr;
    logic [ADDR_W-1:0]    rd_addr;
    logic [ADDR_W-1:0]    nb_addr;
    logic [COORD_W-1:0]   nb_x, nb_y, nb_z;
    logic                 eval_outside;
    logic                 exposed;
    logic [FACE_W-1:0]    pick_face;
    logic [NUM_FACES-1:0] pick_bit;
    logic [NUM_FACES-1:0] mask_left;
    logic                 out_free;

    localparam logic [COORD_W-1:0] CoordMax = COORD_W'(SIDE - 1);

    // linear voxel address
    function automatic logic [ADDR_W-1:0] cell_addr(logic [COORD_W-1:0] x,
                                                    logic [COORD_W-1:0] y,
                                                    logic [COORD_W-1:0] z);
        localparam logic [ADDR_W-1:0] Row   = ADDR_W'(SIDE);
        localparam logic [ADDR_W-1:0] Plane = ADDR_W'(SIDE * SIDE);
        return ADDR_W'(x) + ADDR_W'(y) * Row + ADDR_W'(z) * Plane;
    endfunction

    // neighbour beyond the cube boundary for a given face
    function automatic logic face_outside(in_item_t it, logic [FACE_W-1:0] f);
        logic r;
        case (f)
            FACE_LEFT:   r = (it.pos_x == '0);
            FACE_RIGHT:  r = (it.pos_x == CoordMax);
            FACE_BOTTOM: r = (it.pos_y == '0);
            FACE_TOP:    r = (it.pos_y == CoordMax);
            FACE_BACK:   r = (it.pos_z == '0);
            FACE_FRONT:  r = (it.pos_z == CoordMax);
            default:     r = 1'b1;
        endcase
        return r;
    endfunction

    // neighbour coordinates for the read face
    always_comb
    begin
        nb_x = item_reg.pos_x;
        nb_y = item_reg.pos_y;
        nb_z = item_reg.pos_z;
        case (cmd.rd_face)
            FACE_LEFT:   nb_x = item_reg.pos_x - 1'b1;
            FACE_RIGHT:  nb_x = item_reg.pos_x + 1'b1;
            FACE_BOTTOM: nb_y = item_reg.pos_y - 1'b1;
            FACE_TOP:    nb_y = item_reg.pos_y + 1'b1;
            FACE_BACK:   nb_z = item_reg.pos_z - 1'b1;
            FACE_FRONT:  nb_z = item_reg.pos_z + 1'b1;
            default:     nb_x = item_reg.pos_x;
        endcase
    end

    assign wr_addr = cell_addr(in_item.pos_x, in_item.pos_y, in_item.pos_z);
    assign nb_addr = cell_addr(nb_x, nb_y, nb_z);
    assign rd_addr = cmd.rd_nb ? nb_addr
                               : cell_addr(item_reg.pos_x, item_reg.pos_y, item_reg.pos_z);

    // voxel store, single port, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.wr_voxel)
        begin
            mem[wr_addr] <= in_item.block_value;
        end
        else if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // captured item
    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            item_reg <= in_item;
        end
    end

    // configuration codes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            solid_reg <= SOLID_RESET;
            air_reg   <= AIR_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SOLID: solid_reg <= cfg_data;
                REG_AIR:   air_reg   <= cfg_data;
                default:   solid_reg <= solid_reg;
            endcase
        end
    end

    // neighbour evaluation
    assign eval_outside = face_outside(item_reg, cmd.eval_face);
    assign exposed      = eval_outside || (rd_data_reg == air_reg);

    // lowest pending face
    always_comb
    begin
        pick_face = '0;
        for (int i = NUM_FACES - 1; i >= 0; i--)
        begin
            if (mask_reg[i])
            begin
                pick_face = FACE_W'(i);
            end
        end
    end

    assign pick_bit  = NUM_FACES'(1) << pick_face;
    assign mask_left = mask_reg & ~pick_bit;

    // exposed-face mask update
    always_comb
    begin
        mask_next = mask_reg;
        if (cmd.clr_mask)
        begin
            mask_next = '0;
        end
        else if (cmd.eval_en && exposed)
        begin
            mask_next = mask_reg | (NUM_FACES'(1) << cmd.eval_face);
        end
        else if (cmd.emit)
        begin
            mask_next = mask_left;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg <= '0;
        end
        else
        begin
            mask_reg <= mask_next;
        end
    end

    // running quad counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.clr_count)
        begin
            count_reg <= '0;
        end
        else if (cmd.emit)
        begin
            count_reg <= count_reg + 1'b1;
        end
    end

    // output register
    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            out_item_reg.quad_x      <= item_reg.pos_x;
            out_item_reg.quad_y      <= item_reg.pos_y;
            out_item_reg.quad_z      <= item_reg.pos_z;
            out_item_reg.face        <= pick_face;
            out_item_reg.vertex_base <= {count_reg, 2'b00};
            out_item_reg.last        <= (mask_left == '0);
        end
    end

    assign out_item  = out_item_reg;
    assign out_valid = out_valid_reg;

    // status back to the controller
    assign status.in_kind      = in_item.kind;
    assign status.in_inside    = coord_inside(in_item.pos_x, in_item.pos_y, in_item.pos_z);
    assign status.centre_solid = (rd_data_reg == solid_reg);
    assign status.mask_any     = (mask_reg != '0);
    assign status.out_free     = out_free;

endmodule

>>> rtl/vfcm_checker.sv
// ---------------------------------------------------------------------------
// vfcm_checker
// Port-level checks on the mesher, bound to the top level.
// ---------------------------------------------------------------------------
`include "voxel_face_cull_mesher_unit_defines.svh"

module vfcm_checker
    import vfcm_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input in_item_t             in_item,
    input logic                 out_valid,
    input logic                 out_ready,
    input out_item_t            out_item
);

    logic mesh_taken;

    assign mesh_taken = in_valid && in_ready && (in_item.kind == KIND_MESH)
                        && coord_inside(in_item.pos_x, in_item.pos_y, in_item.pos_z);

    // a stalled quad holds
    `VFCM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_item), "quad changed while stalled")

    // a mesh item blocks input while its neighbours are read
    `VFCM_ASSERT_NEXT(a_mesh_busy, clk, rst_n, mesh_taken, !in_ready, "input taken during mesh")

    // vertex base is a multiple of four
    `VFCM_ASSERT_SAME(a_base_align, clk, rst_n, out_valid, out_item.vertex_base[1:0] == 2'b00, "vertex base misaligned")

    // face number in range
    `VFCM_ASSERT_SAME(a_face_range, clk, rst_n, out_valid, out_item.face <= FACE_FRONT, "face number out of range")

endmodule

bind voxel_face_cull_mesher_unit vfcm_checker u_vfcm_checker (.*);
